// ===== rtl/assert_macros.svh =====
// Assertion macros used by the fixed-point ALU back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/fxalu_pkg.sv =====
// Package: command codes, default widths and pipeline constants for the fixed-point ALU.
package fxalu_pkg;
  localparam int WordBits     = 32;
  localparam int FractionBits = 8;
  localparam int FieldBits    = 32;
  localparam int CmdBits      = 4;
  localparam int QueueDepth   = 4;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_INC = 4'd4, CMD_DEC = 4'd5, CMD_MIN = 4'd6, CMD_MAX = 4'd7,
    CMD_FROM_INT = 4'd8, CMD_TO_INT = 4'd9
  } cmd_t;

  // Operation class chosen by the front end.
  typedef enum logic [1:0] {
    OP_SIMPLE = 2'd0,
    OP_MUL    = 2'd1,
    OP_DIV    = 2'd2
  } op_class_t;
endpackage

// ===== rtl/fixed_point_q24_8_alu_core.sv =====
// Top level of the Q24.8 fixed-point ALU: front end, queue and back end.
// Usage:
//  Input word: command, operand_a, operand_b on in_valid/in_ready.
//  Output word: result, divide_by_zero on out_valid/out_ready.
//  Every word yields exactly one result word, in order.
//  Front end registers the word and computes add/sub/inc/dec/min/max/
//  from_int/to_int itself; mul and div are marked for the back end.
//  A four-entry queue decouples front and back so each stalls alone.
//  Back end is a lockstep pipeline: one prep stage (magnitudes, two
//  partial products), then WORD_BITS+FRACTION_BITS restoring divide steps,
//  one quotient bit per stage, then the output register.
//  Path of each word, with no stall: front register, queue, prep stage,
//  divide steps, output register; every command takes the same path.
//  Throughput: one word per cycle while out_ready stays high.
//  Receiver stall freezes the back pipe; the queue then fills and the
//  front end drops in_ready. Reset (rst, synchronous) empties all stages.
module fixed_point_q24_8_alu_core #(
  parameter int WORD_BITS     = fxalu_pkg::WordBits,
  parameter int FRACTION_BITS = fxalu_pkg::FractionBits
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [fxalu_pkg::CmdBits-1:0]          command,
  input  logic signed [fxalu_pkg::FieldBits-1:0] operand_a,
  input  logic signed [fxalu_pkg::FieldBits-1:0] operand_b,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fxalu_pkg::FieldBits-1:0] result,
  output logic                                   divide_by_zero
);
  logic f_valid, f_ready, q_valid, q_ready;
  fxalu_pkg::op_class_t f_class, q_class;
  logic [WORD_BITS-1:0] f_a, f_b, f_simple, q_a, q_b, q_simple;

  fxalu_front #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .operand_a, .operand_b,
    .f_valid, .f_ready, .f_class, .f_a, .f_b, .f_simple
  );

  fxalu_queue #(.WORD_BITS(WORD_BITS), .DEPTH(fxalu_pkg::QueueDepth)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_class(f_class),
    .wr_a(f_a), .wr_b(f_b), .wr_simple(f_simple),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_class(q_class),
    .rd_a(q_a), .rd_b(q_b), .rd_simple(q_simple)
  );

  fxalu_back #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_class, .q_a, .q_b, .q_simple,
    .out_valid, .out_ready, .result, .divide_by_zero
  );
endmodule

// ===== rtl/fxalu_front.sv =====
// Front end: accepts commands, computes the simple ops and classifies mul/div.
module fxalu_front #(
  parameter int WORD_BITS     = fxalu_pkg::WordBits,
  parameter int FRACTION_BITS = fxalu_pkg::FractionBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fxalu_pkg::CmdBits-1:0]        command,
  input  logic signed [fxalu_pkg::FieldBits-1:0] operand_a,
  input  logic signed [fxalu_pkg::FieldBits-1:0] operand_b,
  output logic                                 f_valid,
  input  logic                                 f_ready,
  output fxalu_pkg::op_class_t                 f_class,
  output logic [WORD_BITS-1:0]                 f_a,
  output logic [WORD_BITS-1:0]                 f_b,
  output logic [WORD_BITS-1:0]                 f_simple
);
  localparam int W = WORD_BITS;
  logic signed [W-1:0] a_w, b_w;
  logic [W-1:0] simple_next;
  fxalu_pkg::op_class_t class_next;
  logic accept;

  // Sign-extend or wrap the 32-bit fields to the word.
  always_comb begin
    if (W >= fxalu_pkg::FieldBits) begin
      a_w = W'(operand_a);
      b_w = W'(operand_b);
    end else begin
      a_w = operand_a[W-1:0];
      b_w = operand_b[W-1:0];
    end
  end

  always_comb begin
    simple_next = '0;
    class_next = fxalu_pkg::OP_SIMPLE;
    case (command)
      fxalu_pkg::CMD_ADD:      simple_next = a_w + b_w;
      fxalu_pkg::CMD_SUB:      simple_next = a_w - b_w;
      fxalu_pkg::CMD_MUL:      class_next = fxalu_pkg::OP_MUL;
      fxalu_pkg::CMD_DIV:      class_next = fxalu_pkg::OP_DIV;
      fxalu_pkg::CMD_INC:      simple_next = a_w + W'(1);
      fxalu_pkg::CMD_DEC:      simple_next = a_w - W'(1);
      fxalu_pkg::CMD_MIN:      simple_next = (a_w < b_w) ? a_w : b_w;
      fxalu_pkg::CMD_MAX:      simple_next = (b_w < a_w) ? a_w : b_w;
      fxalu_pkg::CMD_FROM_INT: simple_next = a_w <<< FRACTION_BITS;
      fxalu_pkg::CMD_TO_INT:   simple_next = a_w >>> FRACTION_BITS;
      default:                 simple_next = '0;
    endcase
  end

  assign in_ready = !f_valid || f_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
    if (accept) begin
      f_class  <= class_next;
      f_a      <= a_w;
      f_b      <= b_w;
      f_simple <= simple_next;
    end
  end
endmodule

// ===== rtl/fxalu_queue.sv =====
// Short FIFO between front and back end.
module fxalu_queue #(
  parameter int WORD_BITS = fxalu_pkg::WordBits,
  parameter int DEPTH     = fxalu_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  fxalu_pkg::op_class_t wr_class,
  input  logic [WORD_BITS-1:0] wr_a,
  input  logic [WORD_BITS-1:0] wr_b,
  input  logic [WORD_BITS-1:0] wr_simple,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output fxalu_pkg::op_class_t rd_class,
  output logic [WORD_BITS-1:0] rd_a,
  output logic [WORD_BITS-1:0] rd_b,
  output logic [WORD_BITS-1:0] rd_simple
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  fxalu_pkg::op_class_t q_class [DEPTH];
  logic [WORD_BITS-1:0] q_a [DEPTH];
  logic [WORD_BITS-1:0] q_b [DEPTH];
  logic [WORD_BITS-1:0] q_s [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic push, pop;

  assign wr_ready = count != (AW+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_class  = q_class[rd_ptr];
  assign rd_a      = q_a[rd_ptr];
  assign rd_b      = q_b[rd_ptr];
  assign rd_simple = q_s[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
    if (push) begin
      q_class[wr_ptr] <= wr_class;
      q_a[wr_ptr]     <= wr_a;
      q_b[wr_ptr]     <= wr_b;
      q_s[wr_ptr]     <= wr_simple;
    end
  end
endmodule

// ===== rtl/fxalu_back.sv =====
// Back end: in-order pipeline with a staged multiplier and a pipelined restoring divider.
`include "assert_macros.svh"
module fxalu_back #(
  parameter int WORD_BITS     = fxalu_pkg::WordBits,
  parameter int FRACTION_BITS = fxalu_pkg::FractionBits
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  fxalu_pkg::op_class_t                   q_class,
  input  logic [WORD_BITS-1:0]                   q_a,
  input  logic [WORD_BITS-1:0]                   q_b,
  input  logic [WORD_BITS-1:0]                   q_simple,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fxalu_pkg::FieldBits-1:0] result,
  output logic                                   divide_by_zero
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int NB = W + F;          // dividend bits, quotient bits
  localparam int H  = (W + 1) / 2;    // multiplier half width
  localparam int S  = NB + 1;         // stages: prep, NB divide steps
  localparam int PW = 2 * W;

  // Pipeline carries all classes through S stages so ordering is kept.
  logic                 v   [1:S];
  fxalu_pkg::op_class_t cl  [1:S];
  logic [W-1:0]         simp[1:S];
  logic                 neg [1:S];
  logic                 dz  [1:S];
  logic [W-1:0]         dvs [1:S];
  logic [NB-1:0]        num [1:S];   // shifts out dividend, shifts in quotient
  logic [W:0]           rem [1:S];
  logic [PW-1:0]        pp_lo;       // low partial product, used in stage 1 only
  logic [PW-1:0]        pp1 [1:S];
  logic [PW-1:0]        prod;
  logic                 adv;
  logic [W-1:0]         ma, mb, res_next;

  // Final register plus stall: whole pipe advances together.
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  assign ma = q_a[W-1] ? (~q_a + W'(1)) : q_a;
  assign mb = q_b[W-1] ? (~q_b + W'(1)) : q_b;

  // Stage 1 entry from queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[1] <= 1'b0;
    end else if (adv) begin
      v[1] <= q_valid;
    end
    if (adv) begin
      cl[1]   <= q_class;
      simp[1] <= q_simple;
      neg[1]  <= q_a[W-1] ^ q_b[W-1];
      dz[1]   <= (q_b == '0);
      dvs[1]  <= mb;
      num[1]  <= {ma, F'(0)};
      rem[1]  <= '0;
      // Two half-width partial products; upper half of mb times ma.
      pp_lo   <= PW'(ma) * PW'(mb[H-1:0]);
      pp1[1]  <= PW'(ma) * PW'(mb[W-1:H]);
    end
  end

  // One restoring divide step per stage.
  for (genvar s = 1; s < S; s++) begin : g_div
    logic [W:0] r_sh, r_sub;
    logic       take;
    assign r_sh  = {rem[s][W-1:0], num[s][NB-1]};
    assign r_sub = r_sh - {1'b0, dvs[s]};
    assign take  = !r_sub[W];
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
      if (adv) begin
        cl[s+1]   <= cl[s];
        simp[s+1] <= simp[s];
        neg[s+1]  <= neg[s];
        dz[s+1]   <= dz[s];
        dvs[s+1]  <= dvs[s];
        rem[s+1]  <= take ? r_sub : r_sh;
        num[s+1]  <= {num[s][NB-2:0], take};
        pp1[s+1]  <= (s == 1) ? (pp_lo + (pp1[s] << H)) : pp1[s];
      end
    end
  end

  // Magnitude product lives in pp1 from stage 2 on.
  assign prod = neg[S] ? (~pp1[S] + PW'(1)) : pp1[S];

  always_comb begin
    case (cl[S])
      fxalu_pkg::OP_MUL: res_next = prod[F +: W];
      fxalu_pkg::OP_DIV: res_next = dz[S] ? '0 :
                           (neg[S] ? (~num[S][W-1:0] + W'(1)) : num[S][W-1:0]);
      default:           res_next = simp[S];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[S];
    end
    if (adv) begin
      result         <= fxalu_pkg::FieldBits'(res_next[W-1:0]);
      divide_by_zero <= (cl[S] == fxalu_pkg::OP_DIV) && dz[S];
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result), "result changed while stalled")
  `ASSERT_IMPL(a_dz_zero, clk, rst, out_valid && divide_by_zero, result == '0, "divide by zero with nonzero result")
  `ASSERT_IMPL(a_stall_q, clk, rst, out_valid && !out_ready, !q_ready, "queue drained during stall")
endmodule

// ===== sim/tb_fixed_point_q24_8_alu_core.sv =====
// Testbench for the Q24.8 fixed-point ALU core: directed table plus random words, checked in order.
module tb_fixed_point_q24_8_alu_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency  = fxalu_pkg::WordBits + fxalu_pkg::FractionBits + 4;
  localparam int MaxCycle = 2000000;

  typedef struct {
    logic [3:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_word_t;

  typedef struct {
    logic signed [31:0] res;
    logic               dz;
  } alu_out_t;

  // directed row: word plus an optional typed-in result
  typedef struct {
    alu_word_t w;
    logic      known;
    alu_out_t  o;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] command = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result;
  logic divide_by_zero;

  alu_out_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;  // forces a long receiver stall

  fixed_point_q24_8_alu_core dut (.*);

  always #5 clk = ~clk;

  // Arithmetic of the block; mul and div work on 64-bit signed operands.
  function automatic alu_out_t alu_compute(alu_word_t w);
    alu_out_t o;
    logic signed [63:0] a, b, p, q;
    logic signed [127:0] prod;
    o.res = '0;
    o.dz  = 1'b0;
    a = w.a;
    b = w.b;
    case (w.cmd)
      fxalu_pkg::CMD_ADD:      o.res = w.a + w.b;
      fxalu_pkg::CMD_SUB:      o.res = w.a - w.b;
      fxalu_pkg::CMD_MUL: begin
        prod = 128'(a) * 128'(b);
        o.res = prod[fxalu_pkg::FractionBits +: 32];
      end
      fxalu_pkg::CMD_DIV: begin
        if (b == 0) begin
          o.dz = 1'b1;
        end else begin
          p = a <<< fxalu_pkg::FractionBits;  // 40 significant bits, fits 64
          q = p / b;                          // truncates toward zero
          o.res = q[31:0];
        end
      end
      fxalu_pkg::CMD_INC:      o.res = w.a + 32'sd1;
      fxalu_pkg::CMD_DEC:      o.res = w.a - 32'sd1;
      fxalu_pkg::CMD_MIN:      o.res = (w.a < w.b) ? w.a : w.b;
      fxalu_pkg::CMD_MAX:      o.res = (w.b < w.a) ? w.a : w.b;
      fxalu_pkg::CMD_FROM_INT: o.res = w.a <<< fxalu_pkg::FractionBits;
      fxalu_pkg::CMD_TO_INT:   o.res = w.a >>> fxalu_pkg::FractionBits;
      default:                 o.res = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp_v, cycles);
    errors++;
  endtask

  // Sender: drive one word, hold until accepted.
  task automatic send_word(alu_word_t w);
    command   <= w.cmd;
    operand_a <= w.a;
    operand_b <= w.b;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 4)) - 32'd2);
      3: return $signed($urandom_range(0, 8191)) - 32'sd4096;
      default: return $signed($urandom());
    endcase
  endfunction

  // Expected results are queued when the word is accepted.
  always @(posedge clk) begin
    alu_word_t w;
    if (!rst && in_valid && in_ready) begin
      w.cmd = command;
      w.a = operand_a;
      w.b = operand_b;
      pending_results.push_back(alu_compute(w));
    end
  end

  // Checker: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", result, '0);
      end else begin
        e = pending_results.pop_front();
        if (result !== e.res) report_mismatch("result", result, e.res);
        if (divide_by_zero !== e.dz) report_mismatch("divide_by_zero", 32'(divide_by_zero), 32'(e.dz));
      end
    end
  end

  // Receiver: random stalls, plus a long hold when asked.
  always @(posedge clk) begin
    if (rst || long_hold) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 50) != 0);
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("timeout after %0d cycles", cycles);
      $display("** fixed_point_q24_8_alu_core: FAILED **");
      $finish;
    end
  end

  // Long receiver hold, counted in its own process.
  initial begin
    wait (!rst);
    repeat (200) @(posedge clk);
    long_hold = 1'b1;
    repeat (300) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    row_t rows[$];
    row_t r;
    alu_word_t w;
    alu_out_t o;
    int n;

    // directed table: extremes, every command, zero divisor, unused codes
    rows = '{
      '{'{fxalu_pkg::CMD_ADD, 32'sh7fffffff, 32'sd1}, 1'b1, '{32'sh80000000, 1'b0}},
      '{'{fxalu_pkg::CMD_SUB, 32'sh80000000, 32'sd1}, 1'b1, '{32'sh7fffffff, 1'b0}},
      '{'{fxalu_pkg::CMD_MUL, 32'sh00000100, 32'sh00000100}, 1'b1, '{32'sh00000100, 1'b0}},
      '{'{fxalu_pkg::CMD_MUL, 32'sh80000000, 32'sh80000000}, 1'b0, '{0, 0}},
      '{'{fxalu_pkg::CMD_MUL, 32'sh7fffffff, 32'shffffffff}, 1'b0, '{0, 0}},
      '{'{fxalu_pkg::CMD_DIV, 32'sh00000300, 32'sh00000000}, 1'b1, '{32'sh0, 1'b1}},
      '{'{fxalu_pkg::CMD_DIV, 32'sh80000000, 32'shffffffff}, 1'b0, '{0, 0}},
      '{'{fxalu_pkg::CMD_DIV, 32'sh7fffffff, 32'sh00000001}, 1'b0, '{0, 0}},
      '{'{fxalu_pkg::CMD_DIV, 32'shfffffd00, 32'sh00000200}, 1'b0, '{0, 0}},
      '{'{fxalu_pkg::CMD_INC, 32'sh7fffffff, 32'sh0}, 1'b1, '{32'sh80000000, 1'b0}},
      '{'{fxalu_pkg::CMD_DEC, 32'sh80000000, 32'sh0}, 1'b1, '{32'sh7fffffff, 1'b0}},
      '{'{fxalu_pkg::CMD_MIN, 32'sh80000000, 32'sh7fffffff}, 1'b1, '{32'sh80000000, 1'b0}},
      '{'{fxalu_pkg::CMD_MAX, 32'sh80000000, 32'sh7fffffff}, 1'b1, '{32'sh7fffffff, 1'b0}},
      '{'{fxalu_pkg::CMD_MIN, 32'sh00000005, 32'sh00000005}, 1'b1, '{32'sh00000005, 1'b0}},
      '{'{fxalu_pkg::CMD_FROM_INT, 32'sh00ffffff, 32'sh0}, 1'b1, '{32'shffffff00, 1'b0}},
      '{'{fxalu_pkg::CMD_TO_INT, 32'shffffff01, 32'sh0}, 1'b1, '{32'shffffffff, 1'b0}},
      '{'{fxalu_pkg::CMD_TO_INT, 32'sh80000000, 32'sh0}, 1'b1, '{32'shff800000, 1'b0}},
      '{'{4'd10, 32'sh12345678, 32'sh1}, 1'b1, '{32'sh0, 1'b0}},
      '{'{4'd15, 32'shffffffff, 32'shffffffff}, 1'b1, '{32'sh0, 1'b0}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.known) begin
        o = alu_compute(r.w);
        // a typed-in row that disagrees with the predictor is a table error
        if (o.res !== r.o.res || o.dz !== r.o.dz)
          report_mismatch($sformatf("table row %0d", i), o.res, r.o.res);
      end
      send_word(r.w);
      idle_gap();
    end

    // random words; mostly real commands, a few unused codes
    for (n = 0; n < 1700; n++) begin
      w.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
      w.a = rand_operand();
      w.b = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_operand();
      send_word(w);
      // one pause until everything has drained
      if (n == 900) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end else if (n < 150 || n > 1200) begin
        idle_gap();
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("** fixed_point_q24_8_alu_core: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu_core: FAILED **");
    end
    $finish;
  end
endmodule
